/* rtl/core/hftq_pkg.sv */
// Package for the heightfield triangle query block.
// Holds grid geometry, field widths and the state encodings; no dependencies.
package hftq_pkg;

  localparam int GRID_RES   = 64;
  localparam int GRID_SIDE  = GRID_RES + 1;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(GRID_CELLS);
  localparam int TILE_W     = 7;   // width of cell_x / cell_z
  localparam int COORD_W    = 23;  // query coordinate, 16 fraction bits
  localparam int OFF_W      = 17;  // cell offset 0 .. 1.0 in Q.16
  localparam int H_W        = 32;  // grid height, Q16.16
  localparam int MAG_W      = 35;  // normal component magnitude before scaling
  localparam int NMAG_W     = 30;  // magnitude after scaling into [2^29, 2^30)
  localparam int SS_W       = 64;  // sum of squares
  localparam int LEN_W      = 32;  // vector length
  localparam int Q_W        = 17;  // raw quotient
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 88;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // main sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_SCALE,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_LEN,
    ST_OUT
  } top_state_t;

  // length / divide unit
  typedef enum logic [1:0] {
    N_IDLE,
    N_SQRT,
    N_LOAD,
    N_DIV
  } norm_state_t;

endpackage

/* rtl/core/hftq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hftq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/hftq_norm.sv */
// Length and scaling unit: bit-pair integer square root, then three
// restoring divides giving Q1.15 magnitudes. Depends on hftq_pkg.
module hftq_norm import hftq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SS_W-1:0]   sum_sq,
  input  logic [NMAG_W-1:0] mag_x,
  input  logic [NMAG_W-1:0] mag_y,
  input  logic [NMAG_W-1:0] mag_z,
  output logic              done,
  output logic [15:0]       q_x,
  output logic [15:0]       q_y,
  output logic [15:0]       q_z
);

  norm_state_t st_r, st_nxt;
  logic [SS_W-1:0]  v_r, res_r, bit_r;
  logic [LEN_W-1:0] len_r;
  logic [47:0]      rem_r, dvs_r;
  logic [Q_W-1:0]   q_r;
  logic [4:0]       cnt_r;
  logic [1:0]       comp_r;
  logic [15:0]      qx_r, qy_r, qz_r;
  logic             done_r;

  logic [SS_W-1:0]   trial;
  logic              sq_ge;
  logic [SS_W-1:0]   res_step;
  logic [NMAG_W-1:0] m_sel;
  logic              dv_ge;
  logic [Q_W-1:0]    q_step;
  logic [15:0]       q_sat;

  // square root step
  assign trial    = res_r + bit_r;
  assign sq_ge    = (v_r >= trial);
  assign res_step = sq_ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);

  // divide step
  always_comb begin
    case (comp_r)
      2'd0:    m_sel = mag_x;
      2'd1:    m_sel = mag_y;
      default: m_sel = mag_z;
    endcase
  end
  assign dv_ge  = (rem_r >= dvs_r);
  assign q_step = {q_r[Q_W-2:0], dv_ge};
  assign q_sat  = (q_step[16] | q_step[15]) ? 16'h7FFF : q_step[15:0];

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      N_IDLE:  if (start) st_nxt = N_SQRT;
      N_SQRT:  if (bit_r[0]) st_nxt = N_LOAD;
      N_LOAD:  st_nxt = N_DIV;
      N_DIV: begin
        if (cnt_r == 5'd0) begin
          st_nxt = (comp_r == 2'd2) ? N_IDLE : N_LOAD;
        end
      end
      default: st_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= N_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == N_DIV) && (cnt_r == 5'd0) && (comp_r == 2'd2);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      N_IDLE: begin
        v_r    <= sum_sq;
        res_r  <= '0;
        bit_r  <= SS_W'(1) << 62;
        comp_r <= 2'd0;
      end
      N_SQRT: begin
        if (sq_ge) v_r <= v_r - trial;
        res_r <= res_step;
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          len_r <= (res_step == '0) ? LEN_W'(1) : res_step[LEN_W-1:0];
        end
      end
      N_LOAD: begin
        rem_r <= (48'(m_sel) << 15) + 48'(len_r >> 1);
        dvs_r <= 48'(len_r) << 16;
        q_r   <= '0;
        cnt_r <= 5'(Q_W - 1);
      end
      N_DIV: begin
        if (dv_ge) rem_r <= rem_r - dvs_r;
        dvs_r <= dvs_r >> 1;
        q_r   <= q_step;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          case (comp_r)
            2'd0:    qx_r <= q_sat;
            2'd1:    qy_r <= q_sat;
            default: qz_r <= q_sat;
          endcase
          comp_r <= comp_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign q_x  = qx_r;
  assign q_y  = qy_r;
  assign q_z  = qz_r;

endmodule

/* rtl/core/heightfield_triangle_query_top.sv */
// Heightfield triangle query: a write transaction stores one grid height.
// A query result passes through grid RAM reads, the shared multiplier, a one-bit-per-cycle
// scaling loop, squaring, the length unit (32-step square root, then three divides of one
// load and 17 steps each) and the output register; in_tready returns with the result.
// Reset (rst_n, synchronous) clears sequencers and output valid, not the grid. Uses hftq_pkg.
module heightfield_triangle_query_top import hftq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // cell_x[6:0], cell_z[13:7], sample_height[45:14], query_x[68:46], query_z[91:69]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // height_out[31:0], normal_x[47:32], normal_y[63:48], normal_z[79:64], out_of_range[80]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  top_state_t state_r, state_nxt;

  // input fields
  logic [TILE_W-1:0]  cell_x, cell_z;
  logic [H_W-1:0]     sample_height;
  logic [COORD_W-1:0] query_x, query_z;
  assign cell_x        = in_tdata[6:0];
  assign cell_z        = in_tdata[13:7];
  assign sample_height = in_tdata[45:14];
  assign query_x       = in_tdata[68:46];
  assign query_z       = in_tdata[91:69];

  logic accept, slot_free;
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_tvalid || out_tready;

  // coordinate clamp to the last cell
  localparam logic [COORD_W-1:0] LIM = COORD_W'(GRID_RES) << 16;
  logic [TILE_W-1:0] tx_c, tz_c;
  logic [OFF_W-1:0]  ox_c, oz_c;
  logic              oor_c;
  always_comb begin
    logic [COORD_W-1:0] cx, cz;
    cx    = (query_x > LIM) ? LIM : query_x;
    cz    = (query_z > LIM) ? LIM : query_z;
    oor_c = (query_x > LIM) || (query_z > LIM);
    tx_c  = cx[22:16];
    ox_c  = {1'b0, cx[15:0]};
    tz_c  = cz[22:16];
    oz_c  = {1'b0, cz[15:0]};
    if (tx_c >= TILE_W'(GRID_RES)) begin
      tx_c = TILE_W'(GRID_RES - 1);
      ox_c = OFF_W'(65536);
    end
    if (tz_c >= TILE_W'(GRID_RES)) begin
      tz_c = TILE_W'(GRID_RES - 1);
      oz_c = OFF_W'(65536);
    end
  end

  logic [TILE_W-1:0]     tx_r, tz_r;
  logic [OFF_W-1:0]      ox_r, oz_r;
  logic                  oor_r;
  logic signed [H_W-1:0] h1_r, h2_r, h3_r, h4_r;

  // grid memory
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [H_W-1:0]    ram_rdata;
  logic [TILE_W-1:0] rd_x, rd_z;

  assign ram_we = accept && (in_tuser == ACT_WRITE) &&
                  (cell_x <= TILE_W'(GRID_RES)) && (cell_z <= TILE_W'(GRID_RES));
  assign ram_waddr = ADDR_W'(cell_z) * ADDR_W'(GRID_SIDE) + ADDR_W'(cell_x);
  assign ram_raddr = ADDR_W'(rd_z) * ADDR_W'(GRID_SIDE) + ADDR_W'(rd_x);

  hftq_ram #(.WIDTH(H_W), .DEPTH(GRID_CELLS)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (sample_height),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // triangle selection and normal
  logic upper, diag;
  assign upper = (ox_r <= oz_r);
  assign diag  = (ox_r == oz_r);

  logic signed [H_W:0] d_a, d_b;
  always_comb begin
    if (upper) begin
      d_a = 33'(h3_r) - 33'(h2_r);
      d_b = 33'(h2_r) - 33'(h1_r);
    end else begin
      d_a = 33'(h4_r) - 33'(h1_r);
      d_b = 33'(h3_r) - 33'(h4_r);
    end
  end

  logic signed [33:0] nx_c, nz_c;
  logic [17:0]        ny_c;
  always_comb begin
    if (upper) begin
      nx_c = 34'(h2_r) - 34'(h3_r);
      nz_c = 34'(h1_r) - 34'(h2_r);
    end else begin
      nx_c = 34'(h1_r) - 34'(h4_r);
      nz_c = 34'(h4_r) - 34'(h3_r);
    end
    ny_c = 18'd65536;
    if (diag) begin
      nx_c = nx_c + 34'(h1_r) - 34'(h4_r);
      nz_c = nz_c + 34'(h4_r) - 34'(h3_r);
      ny_c = 18'd131072;
    end
  end

  logic [MAG_W-1:0] ax_r, ay_r, az_r, m_max;
  logic             neg_x_r, neg_z_r;
  assign m_max = (ax_r > ay_r) ? ((ax_r > az_r) ? ax_r : az_r)
                               : ((ay_r > az_r) ? ay_r : az_r);

  // shared multiplier
  logic signed [MAG_W-1:0] mul_a;
  logic signed [30:0]      mul_b;
  logic signed [65:0]      prod_r;
  logic signed [52:0]      acc_r;
  logic [SS_W-1:0]         ss_r;
  logic [SS_W-1:0]         ss_full;

  // full sum of squares, including the square still in the product register
  assign ss_full = ss_r + SS_W'(prod_r[61:0]);

  // length unit
  logic        norm_start, norm_done;
  logic [15:0] q_x, q_y, q_z;

  hftq_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (norm_start),
    .sum_sq (ss_full),
    .mag_x  (ax_r[NMAG_W-1:0]),
    .mag_y  (ay_r[NMAG_W-1:0]),
    .mag_z  (az_r[NMAG_W-1:0]),
    .done   (norm_done),
    .q_x    (q_x),
    .q_y    (q_y),
    .q_z    (q_z)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept && in_tuser == ACT_QUERY) state_nxt = ST_RD0;
      ST_RD0:   state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_RD3;
      ST_RD3:   state_nxt = ST_RD4;
      ST_RD4:   state_nxt = ST_MUL0;
      ST_MUL0:  state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_SCALE;
      ST_SCALE: begin
        if (m_max < (MAG_W'(1) << 30) && m_max >= (MAG_W'(1) << 29)) state_nxt = ST_SQ0;
      end
      ST_SQ0:   state_nxt = ST_SQ1;
      ST_SQ1:   state_nxt = ST_SQ2;
      ST_SQ2:   state_nxt = ST_SQ3;
      ST_SQ3:   state_nxt = ST_LEN;
      ST_LEN:   if (norm_done) state_nxt = ST_OUT;
      ST_OUT:   if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    norm_start = (state_r == ST_SQ3);
    rd_x       = tx_r;
    rd_z       = tz_r;
    mul_a      = MAG_W'(d_a);
    mul_b      = 31'(ox_r);
    case (state_r)
      ST_RD1:  rd_z = tz_r + TILE_W'(1);
      ST_RD2: begin
        rd_x = tx_r + TILE_W'(1);
        rd_z = tz_r + TILE_W'(1);
      end
      ST_RD3:  rd_x = tx_r + TILE_W'(1);
      ST_MUL1: begin
        mul_a = MAG_W'(d_b);
        mul_b = 31'(oz_r);
      end
      ST_SQ0: begin
        mul_a = MAG_W'(ax_r[NMAG_W-1:0]);
        mul_b = 31'(ax_r[NMAG_W-1:0]);
      end
      ST_SQ1: begin
        mul_a = MAG_W'(ay_r[NMAG_W-1:0]);
        mul_b = 31'(ay_r[NMAG_W-1:0]);
      end
      ST_SQ2: begin
        mul_a = MAG_W'(az_r[NMAG_W-1:0]);
        mul_b = 31'(az_r[NMAG_W-1:0]);
      end
      default: ;
    endcase
  end

  // height rounding and saturation
  logic signed [52:0] acc_rnd;
  logic signed [36:0] h_shr;
  logic [H_W-1:0]     h_sat;
  assign acc_rnd = acc_r + 53'sd32768;
  assign h_shr   = 37'(acc_rnd >>> 16);
  assign h_sat   = (h_shr > 37'sh7FFFFFFF)  ? 32'h7FFFFFFF :
                   (h_shr < -37'sh80000000) ? 32'h80000000 : h_shr[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= 66'(mul_a) * 66'(mul_b);
    case (state_r)
      ST_IDLE: begin
        tx_r  <= tx_c;
        tz_r  <= tz_c;
        ox_r  <= ox_c;
        oz_r  <= oz_c;
        oor_r <= oor_c;
      end
      ST_RD1: h1_r <= ram_rdata;
      ST_RD2: h2_r <= ram_rdata;
      ST_RD3: h3_r <= ram_rdata;
      ST_RD4: h4_r <= ram_rdata;
      ST_MUL0: begin
        ax_r    <= nx_c[33] ? MAG_W'(-nx_c) : MAG_W'(nx_c);
        ay_r    <= MAG_W'(ny_c);
        az_r    <= nz_c[33] ? MAG_W'(-nz_c) : MAG_W'(nz_c);
        neg_x_r <= nx_c[33];
        neg_z_r <= nz_c[33];
      end
      ST_MUL1: acc_r <= (53'(h1_r) <<< 16) + 53'(prod_r);
      ST_MUL2: acc_r <= acc_r + 53'(prod_r);
      ST_SCALE: begin
        if (m_max >= (MAG_W'(1) << 30)) begin
          ax_r <= ax_r >> 1;
          ay_r <= ay_r >> 1;
          az_r <= az_r >> 1;
        end else if (m_max < (MAG_W'(1) << 29)) begin
          ax_r <= ax_r << 1;
          ay_r <= ay_r << 1;
          az_r <= az_r << 1;
        end
      end
      ST_SQ1:  ss_r <= SS_W'(prod_r[61:0]);
      ST_SQ2:  ss_r <= ss_r + SS_W'(prod_r[61:0]);
      ST_SQ3:  ss_r <= ss_r + SS_W'(prod_r[61:0]);
      default: ;
    endcase
  end

  // result register
  logic out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic load_out;
  assign load_out = (state_r == ST_OUT) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {7'd0, oor_r,
                     neg_z_r ? (16'd0 - q_z) : q_z,
                     q_y,
                     neg_x_r ? (16'd0 - q_x) : q_x,
                     h_sat};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_query_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == ACT_QUERY) |=> (state_r == ST_RD0))
    else $error("query did not start grid reads");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == ACT_WRITE) |=> (state_r == ST_IDLE))
    else $error("write left idle");

  a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ0) |-> (m_max < (MAG_W'(1) << 30) && m_max >= (MAG_W'(1) << 29)))
    else $error("normal not scaled");

  a_done_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> (state_r == ST_LEN))
    else $error("length unit done outside wait");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("result not presented");

endmodule

/* tb/heightfield_triangle_query_top_tb.sv */
// Testbench for heightfield_triangle_query_top: loads the grid, then checks
// query transactions against an in-bench height/normal calculator. Depends on hftq_pkg.
`timescale 1ns / 1ps

module heightfield_triangle_query_top_tb;
  import hftq_pkg::*;

  typedef struct packed {
    logic           action;
    logic [6:0]     cell_x;
    logic [6:0]     cell_z;
    logic [31:0]    sample_height;
    logic [22:0]    query_x;
    logic [22:0]    query_z;
  } hf_item_t;

  typedef struct packed {
    logic [31:0] height;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        oor;
  } hf_result_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  heightfield_triangle_query_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  hf_item_t    pending_items[$];
  hf_result_t  expected_heights[$];
  logic [31:0] grid_copy [GRID_CELLS];
  int          error_count;
  int          watchdog;
  bit          calm_phase;    // no idling in the last part
  bit          hold_sender;   // sender held off while set
  int          in_gap;
  int          out_gap;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: height and unit normal for one query
  // ---------------------------------------------------------------------------
  function automatic longint floor16(longint v);
    if (v >= 0) return v >>> 16;
    return -((-v + 65535) >>> 16);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] unit_q15(longint unsigned m, longint unsigned len, bit neg);
    longint unsigned q;
    q = (m * 32768 + len / 2) / len;
    if (q > 32767) q = 32767;
    return neg ? 16'(-q) : 16'(q);
  endfunction

  function automatic longint height_at(int x, int z);
    return longint'($signed(grid_copy[z * GRID_SIDE + x]));
  endfunction

  function automatic hf_result_t surface_query(logic [22:0] qx, logic [22:0] qz);
    hf_result_t r;
    longint unsigned cx, cz, lim;
    int tx, tz;
    longint ox, oz;
    longint h1, h2, h3, h4, h, nx, ny, nz;
    longint unsigned ax, ay, az, m, len;
    bit oor;
    oor = 0;
    lim = longint'(GRID_RES) << 16;
    cx = qx;
    cz = qz;
    if (cx > lim) begin cx = lim; oor = 1; end
    if (cz > lim) begin cz = lim; oor = 1; end
    tx = int'(cx >> 16); ox = cx & 16'hFFFF;
    tz = int'(cz >> 16); oz = cz & 16'hFFFF;
    if (tx >= GRID_RES) begin tx = GRID_RES - 1; ox = 65536; end
    if (tz >= GRID_RES) begin tz = GRID_RES - 1; oz = 65536; end
    h1 = height_at(tx, tz);
    h2 = height_at(tx, tz + 1);
    h3 = height_at(tx + 1, tz + 1);
    h4 = height_at(tx + 1, tz);
    if (ox - oz <= 0) begin
      h = h1 * 65536 + (h3 - h2) * ox + (h2 - h1) * oz;
      nx = h2 - h3; ny = 65536; nz = h1 - h2;
      // on the diagonal both triangle normals are summed
      if (ox == oz) begin
        nx += h1 - h4; ny += 65536; nz += h4 - h3;
      end
    end else begin
      h = h1 * 65536 + (h4 - h1) * ox + (h3 - h4) * oz;
      nx = h1 - h4; ny = 65536; nz = h4 - h3;
    end
    h = floor16(h + 32768);
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    if (h < -64'sd2147483648) h = -64'sd2147483648;
    ax = nx < 0 ? -nx : nx;
    ay = ny;
    az = nz < 0 ? -nz : nz;
    m = ax > ay ? ax : ay;
    if (az > m) m = az;
    while (m >= (64'd1 << 30)) begin ax >>= 1; ay >>= 1; az >>= 1; m >>= 1; end
    while (m < (64'd1 << 29)) begin ax <<= 1; ay <<= 1; az <<= 1; m <<= 1; end
    len = int_sqrt(ax * ax + ay * ay + az * az);
    if (len == 0) len = 1;
    r.height = h[31:0];
    r.nx = unit_q15(ax, len, nx < 0);
    r.ny = unit_q15(ay, len, 1'b0);
    r.nz = unit_q15(az, len, nz < 0);
    r.oor = oor;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_write(int x, int z, logic [31:0] hv);
    hf_item_t it;
    it.action = ACT_WRITE;
    it.cell_x = 7'(x);
    it.cell_z = 7'(z);
    it.sample_height = hv;
    it.query_x = 23'($urandom);
    it.query_z = 23'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic push_query(logic [22:0] qx, logic [22:0] qz);
    hf_item_t it;
    it.action = ACT_QUERY;
    it.cell_x = 7'($urandom);
    it.cell_z = 7'($urandom);
    it.sample_height = $urandom;
    it.query_x = qx;
    it.query_z = qz;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] random_height();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  // coordinate: mostly in range, some on edges or beyond
  function automatic logic [22:0] random_coord();
    case ($urandom_range(0, 9))
      0: return 23'(GRID_RES << 16);
      1: return 23'($urandom_range((GRID_RES << 16) + 1, 23'h7FFFFF));
      2: return 23'($urandom_range(0, GRID_RES) << 16);
      default: return 23'($urandom_range(0, GRID_RES << 16));
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_heights.size() != 0 || in_tvalid)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [22:0] c;
    int n;
    rst_n = 1'b0;
    calm_phase = 1'b0;
    hold_sender = 1'b1;
    error_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole grid: every entry written before any read
    for (int z = 0; z < GRID_SIDE; z++)
      for (int x = 0; x < GRID_SIDE; x++)
        push_write(x, z, random_height());
    // writes outside the grid are ignored
    push_write(GRID_RES + 1, 0, 32'hDEAD_BEEF);
    push_write(0, 127, 32'hDEAD_BEEF);
    push_write(127, 127, 32'hDEAD_BEEF);
    hold_sender = 1'b0;

    // directed queries: corners, far edge, beyond grid, diagonal, off-diagonal
    push_query(23'd0, 23'd0);
    push_query(23'(GRID_RES << 16), 23'(GRID_RES << 16));
    push_query(23'h7FFFFF, 23'h7FFFFF);
    push_query(23'h7FFFFF, 23'd0);
    push_query(23'd0, 23'(GRID_RES << 16) + 23'd1);
    push_query(23'h18000, 23'h18000);
    push_query(23'h18001, 23'h18000);
    push_query(23'h18000, 23'h18001);
    push_query(23'h3FFFFF, 23'h2AAAAA);
    push_query(23'h0FFFF, 23'h0FFFF);
    push_query(23'(GRID_RES << 16) - 23'd1, 23'd1);
    // flat patch and extreme slopes around cell (2,2)
    push_write(2, 2, 32'd0); push_write(3, 2, 32'd0);
    push_write(2, 3, 32'd0); push_write(3, 3, 32'd0);
    push_query(23'h24000, 23'h28000);
    push_write(3, 2, 32'h7FFF_FFFF); push_write(2, 3, 32'h8000_0000);
    push_query(23'h28000, 23'h24000);
    push_query(23'h24000, 23'h28000);
    push_query(23'h20000, 23'h20000);

    // pause the sender until all results are back
    wait_drained();
    hold_sender = 1'b1;
    repeat (5) @(posedge clk);
    hold_sender = 1'b0;

    // random mix: mostly queries with occasional rewrites and noise writes
    n = 0;
    while (n < 600) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 7) == 0)
          push_write($urandom_range(GRID_RES + 1, 127), $urandom_range(0, 127), $urandom);
        else
          push_write($urandom_range(0, GRID_RES), $urandom_range(0, GRID_RES),
                     random_height());
      end else begin
        c = random_coord();
        // a share of queries lie on the cell diagonal
        if ($urandom_range(0, 5) == 0) push_query(c, c);
        else push_query(c, random_coord());
      end
      n++;
      if (n == 500) begin
        wait_drained();
        calm_phase = 1'b1;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    hf_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      // previous transaction accepted (or none held): predict it on acceptance
      if (in_tvalid && in_tready) begin
        it = pending_items.pop_front();
        if (it.action == ACT_WRITE) begin
          if (it.cell_x <= GRID_RES && it.cell_z <= GRID_RES)
            grid_copy[it.cell_z * GRID_SIDE + it.cell_x] = it.sample_height;
        end else begin
          expected_heights.push_back(surface_query(it.query_x, it.query_z));
        end
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(1, 16) - 1;
        in_tvalid <= 1'b0;
      end else if (!hold_sender && pending_items.size() != 0) begin
        it = pending_items[0];
        in_tvalid <= 1'b1;
        in_tuser  <= it.action;
        in_tdata  <= {4'd0, it.query_z, it.query_x, it.sample_height, it.cell_z, it.cell_x};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and receiver stalls
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    hf_result_t got;
    hf_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
      watchdog   <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got.height = out_tdata[31:0];
        got.nx = out_tdata[47:32];
        got.ny = out_tdata[63:48];
        got.nz = out_tdata[79:64];
        got.oor = out_tdata[80];
        if (expected_heights.size() == 0) begin
          report_mismatch("unexpected result", got.height, 32'd0);
        end else begin
          want = expected_heights.pop_front();
          if (got.height !== want.height)
            report_mismatch("height_out", got.height, want.height);
          if (got.nx !== want.nx)
            report_mismatch("normal_x", 32'(got.nx), 32'(want.nx));
          if (got.ny !== want.ny)
            report_mismatch("normal_y", 32'(got.ny), 32'(want.ny));
          if (got.nz !== want.nz)
            report_mismatch("normal_z", 32'(got.nz), 32'(want.nz));
          if (got.oor !== want.oor)
            report_mismatch("out_of_range", 32'(got.oor), 32'(want.oor));
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(1, 16) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

endmodule
